[hw/rtl/rtc_pkg.sv]
package rtc_pkg;

   localparam int RateEntriesDefault = 64;
   localparam logic [63:0] Scale1e8 = 64'd100000000;
   localparam logic [62:0] Max63 = {63{1'b1}};

   localparam logic [2:0] ST_DIRECT   = 3'd0;
   localparam logic [2:0] ST_INVERSE  = 3'd1;
   localparam logic [2:0] ST_BRIDGE   = 3'd2;
   localparam logic [2:0] ST_NOTFOUND = 3'd3;
   localparam logic [2:0] ST_BAD      = 3'd4;
   localparam logic [2:0] ST_OVERFLOW = 3'd5;
   localparam logic [2:0] ST_WRITTEN  = 3'd6;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   localparam logic CSR_RATE_COUNT = 1'b0;
   localparam logic CSR_BRIDGE     = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [63:0] amount;
      logic [7:0]  from_currency;
      logic [7:0]  to_currency;
      logic [5:0]  entry_slot;
      logic [7:0]  entry_base;
      logic [7:0]  entry_quote;
      logic [63:0] entry_rate;
   } req_type_type;

   typedef struct packed {
      logic [62:0] converted_amount;
      logic [2:0]  status;
   } rsp_type;

   // handshake between sequencer and muldiv unit
   typedef struct packed {
      logic start;
   } md_ctl_type;

   typedef struct packed {
      logic done;
      logic ovf;
   } md_sts_type;

endpackage

[hw/rtl/rtc_muldiv.sv]
// (x*y)/d: one 64x64 product built from four 32x32 partial products,
// then a bit-serial restoring division of the 128-bit product.
module rtc_muldiv
   import rtc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  md_ctl_type  ctl,
   input  logic [63:0] x,
   input  logic [63:0] y,
   input  logic [63:0] d,
   output md_sts_type  sts,
   output logic [63:0] q
);

   typedef enum logic [3:0] {
      MD_IDLE = 4'b0001,
      MD_MUL  = 4'b0010,
      MD_DIV  = 4'b0100,
      MD_DONE = 4'b1000
   } md_state_type;

   md_state_type state_ff, state_in;
   logic [1:0]   mstep_ff, mstep_in;
   logic [6:0]   dstep_ff, dstep_in;
   logic [127:0] prod_ff, prod_in;
   logic [63:0]  rem_ff, rem_in;
   logic [63:0]  quo_ff, quo_in;
   logic         ovf_ff, ovf_in;
   logic [31:0]  ma, mb;
   logic [63:0]  pp;
   logic [127:0] pp_sh;
   logic [64:0]  rshift;
   logic [64:0]  rdiff;

   always_comb begin
      unique case (mstep_ff)
         2'd0: begin ma = x[31:0];  mb = y[31:0];  pp_sh = 128'(pp); end
         2'd1: begin ma = x[31:0];  mb = y[63:32]; pp_sh = 128'(pp) << 32; end
         2'd2: begin ma = x[63:32]; mb = y[31:0];  pp_sh = 128'(pp) << 32; end
         default: begin ma = x[63:32]; mb = y[63:32]; pp_sh = 128'(pp) << 64; end
      endcase
   end
   assign pp = 64'(ma) * 64'(mb);

   assign rshift = {rem_ff, prod_ff[127]};
   assign rdiff  = rshift - {1'b0, d};

   always_comb begin
      state_in = state_ff;
      mstep_in = mstep_ff;
      dstep_in = dstep_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      ovf_in   = ovf_ff;
      unique case (state_ff)
         MD_IDLE: begin
            if (ctl.start) begin
               state_in = MD_MUL;
               mstep_in = 2'd0;
               prod_in  = '0;
               ovf_in   = 1'b0;
            end
         end
         MD_MUL: begin
            prod_in  = prod_ff + pp_sh;
            mstep_in = mstep_ff + 2'd1;
            if (mstep_ff == 2'd3) begin
               rem_in   = '0;
               quo_in   = '0;
               dstep_in = '0;
               if (d == '0) begin
                  state_in = MD_DONE;
               end else if (prod_in[127:64] >= d) begin
                  quo_in   = '1;
                  ovf_in   = 1'b1;
                  state_in = MD_DONE;
               end else begin
                  state_in = MD_DIV;
               end
            end
         end
         MD_DIV: begin
            prod_in = prod_ff << 1;
            if (!rdiff[64]) begin
               rem_in = rdiff[63:0];
               quo_in = {quo_ff[62:0], 1'b1};
            end else begin
               rem_in = rshift[63:0];
               quo_in = {quo_ff[62:0], 1'b0};
            end
            dstep_in = dstep_ff + 7'd1;
            if (dstep_ff == 7'd127) begin
               state_in = MD_DONE;
            end
         end
         default: state_in = MD_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         mstep_ff <= '0;
      end else begin
         state_ff <= state_in;
         mstep_ff <= mstep_in;
      end
      dstep_ff <= dstep_in;
      prod_ff  <= prod_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      ovf_ff   <= ovf_in;
   end

   assign sts.done = (state_ff == MD_DONE);
   assign sts.ovf  = ovf_ff;
   assign q        = quo_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> state_ff == MD_IDLE) else $error("muldiv start while busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      sts.done |=> !sts.done) else $error("done longer than one cycle");
   a_ovf_sat: assert property (@(posedge clock) disable iff (reset)
      (sts.done && sts.ovf) |-> q == '1) else $error("overflow not saturated");

endmodule

[hw/rtl/rate_table_convert_unit.sv]
// Exchange-rate table with exact fixed-point conversion.
// req_*: a write (req_type 0) loads one table slot; a query (req_type 1)
// converts req_payload.amount. An item transfers when start is high and busy
// is low; busy stays high until its result is out.
// rsp_*: one result per item, shown for a single cycle with rsp_valid.
// The receiver cannot stall; nothing is held back.
// csr_*: register writes (0 entry count, 1 bridge_currency), ready whenever idle.
// Flow: a write passes through S_WRITE and S_FINISH. A query scans the table
// (direct, then inverse, per leg) and makes muldiv passes on the shared
// multiply/divide unit; up to 6 scans and 4 passes per query.
// The table is one memory with a registered read port, read one slot per
// cycle by the scan.
// Reset clears the CSR registers and the sequencer; table contents stay
// undefined until written.
module rate_table_convert_unit
   import rtc_pkg::*;
#(
   parameter int RATE_ENTRIES = RateEntriesDefault
)(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_type_type req_payload,
   output logic         rsp_valid,
   output rsp_type      rsp_payload,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [63:0]  csr_data
);

   localparam int IW = (RATE_ENTRIES > 1) ? $clog2(RATE_ENTRIES) : 1;
   localparam int CW = $clog2(RATE_ENTRIES + 1);

   typedef enum logic [11:0] {
      S_IDLE   = 12'b000000000001,
      S_SCAN   = 12'b000000000010,
      S_CHECK  = 12'b000000000100,
      S_INVMD  = 12'b000000001000,
      S_INVW   = 12'b000000010000,
      S_LEG    = 12'b000000100000,
      S_MD1    = 12'b000001000000,
      S_MD1W   = 12'b000010000000,
      S_MD2    = 12'b000100000000,
      S_MD2W   = 12'b001000000000,
      S_FINISH = 12'b010000000000,
      S_WRITE  = 12'b100000000000
   } state_type;

   logic [7:0]  mem_base  [RATE_ENTRIES];
   logic [7:0]  mem_quote [RATE_ENTRIES];
   logic [63:0] mem_rate  [RATE_ENTRIES];
   logic [7:0]  rd_base_ff, rd_quote_ff;
   logic [63:0] rd_rate_ff;

   state_type   state_ff, state_in;
   req_type_type req_ff;
   logic [6:0]  scan_len_ff;
   logic [7:0]  bridge_ff;
   logic [CW-1:0] n_act;
   logic [CW-1:0] idx_ff, idx_in;
   logic        rd_vld_ff, rd_vld_in;
   logic        inv_ff, inv_in;   // scanning inverse pass
   logic [1:0]  leg_ff, leg_in;   // 0 single, 1 bridge first, 2 bridge second
   logic [7:0]  sfrom, sto;
   logic [63:0] r1_ff, r1_in, r2_ff, r2_in;
   logic [2:0]  kind_ff, kind_in;
   logic [63:0] res_ff, res_in;
   logic        ovf_ff, ovf_in;
   logic        rsp_vld_ff, rsp_vld_in;
   rsp_type     rsp_ff, rsp_in;
   md_ctl_type  md_ctl;
   md_sts_type  md_sts;
   logic [63:0] md_x, md_y, md_d, md_q;
   logic        hit;

   assign n_act = (32'(scan_len_ff) > RATE_ENTRIES) ? CW'(RATE_ENTRIES)
                                                    : CW'(scan_len_ff);

   // memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (state_ff == S_WRITE && 32'(req_ff.entry_slot) < RATE_ENTRIES) begin
         mem_base[IW'(req_ff.entry_slot)]  <= req_ff.entry_base;
         mem_quote[IW'(req_ff.entry_slot)] <= req_ff.entry_quote;
         mem_rate[IW'(req_ff.entry_slot)]  <= req_ff.entry_rate;
      end
      rd_base_ff  <= mem_base[IW'(idx_ff)];
      rd_quote_ff <= mem_quote[IW'(idx_ff)];
      rd_rate_ff  <= mem_rate[IW'(idx_ff)];
   end

   rtc_muldiv u_md (
      .clock (clock),
      .reset (reset),
      .ctl   (md_ctl),
      .x     (md_x),
      .y     (md_y),
      .d     (md_d),
      .sts   (md_sts),
      .q     (md_q)
   );

   always_comb begin
      unique case (leg_ff)
         2'd1:    begin sfrom = req_ff.from_currency; sto = bridge_ff; end
         2'd2:    begin sfrom = bridge_ff; sto = req_ff.to_currency; end
         default: begin sfrom = req_ff.from_currency; sto = req_ff.to_currency; end
      endcase
      if (!inv_ff) begin
         hit = rd_base_ff == sfrom && rd_quote_ff == sto;
      end else begin
         hit = rd_base_ff == sto && rd_quote_ff == sfrom && rd_rate_ff != '0;
      end
   end

   // the stored rate of an inverse hit sits in r1/r2 until the quotient replaces it
   always_comb begin
      md_ctl.start = 1'b0;
      md_x = req_ff.amount;
      md_y = r1_ff;
      md_d = Scale1e8;
      unique case (state_ff)
         S_INVMD, S_INVW: begin
            md_x = Scale1e8;
            md_y = Scale1e8;
            md_d = (leg_ff == 2'd2) ? r2_ff : r1_ff;
         end
         S_MD2, S_MD2W:   begin md_x = res_ff; md_y = r2_ff; end
         default: ;
      endcase
      if (state_ff == S_INVMD || state_ff == S_MD1 || state_ff == S_MD2) begin
         md_ctl.start = 1'b1;
      end
   end

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      rd_vld_in  = 1'b0;
      inv_in     = inv_ff;
      leg_in     = leg_ff;
      r1_in      = r1_ff;
      r2_in      = r2_ff;
      kind_in    = kind_ff;
      res_in     = res_ff;
      ovf_in     = ovf_ff;
      rsp_vld_in = 1'b0;
      rsp_in     = rsp_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               idx_in = '0;
               inv_in = 1'b0;
               ovf_in = 1'b0;
               res_in = '0;
               if (req_payload.req_type == REQ_WRITE) begin
                  state_in = S_WRITE;
               end else if (req_payload.amount[63]) begin
                  kind_in  = ST_BAD;
                  state_in = S_FINISH;
               end else if (req_payload.from_currency == req_payload.to_currency) begin
                  res_in   = req_payload.amount;
                  kind_in  = ST_DIRECT;
                  state_in = S_FINISH;
               end else begin
                  leg_in   = 2'd0;
                  state_in = S_SCAN;
               end
            end
         end
         S_WRITE: begin
            kind_in  = ST_WRITTEN;
            state_in = S_FINISH;
         end
         S_SCAN: begin
            // issue read of idx, compare previous read
            if (rd_vld_ff && hit) begin
               state_in = inv_ff ? S_INVMD : S_CHECK;
               if (leg_ff == 2'd2) r2_in = rd_rate_ff;
               else r1_in = rd_rate_ff;
            end else if (idx_ff == n_act) begin
               if (!rd_vld_ff) begin
                  if (!inv_ff) begin
                     inv_in = 1'b1;
                     idx_in = '0;
                  end else begin
                     // leg not found
                     if (leg_ff == 2'd0 && req_ff.from_currency != bridge_ff &&
                         req_ff.to_currency != bridge_ff) begin
                        leg_in = 2'd1;
                        inv_in = 1'b0;
                        idx_in = '0;
                     end else begin
                        kind_in  = ST_NOTFOUND;
                        res_in   = '0;
                        state_in = S_FINISH;
                     end
                  end
               end
            end else begin
               idx_in    = idx_ff + CW'(1);
               rd_vld_in = 1'b1;
            end
         end
         S_INVMD: state_in = S_INVW;
         S_INVW: begin
            if (md_sts.done) begin
               if (leg_ff == 2'd2) r2_in = md_q;
               else r1_in = md_q;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            // a leg's rate is settled
            if (leg_ff == 2'd0) begin
               kind_in  = inv_ff ? ST_INVERSE : ST_DIRECT;
               state_in = S_MD1;
            end else if (leg_ff == 2'd1) begin
               leg_in   = 2'd2;
               inv_in   = 1'b0;
               idx_in   = '0;
               state_in = S_SCAN;
            end else begin
               kind_in  = ST_BRIDGE;
               state_in = S_MD1;
            end
         end
         S_MD1: state_in = S_MD1W;
         S_MD1W: begin
            if (md_sts.done) begin
               res_in = md_q;
               ovf_in = md_sts.ovf;
               state_in = (kind_ff == ST_BRIDGE && !md_sts.ovf) ? S_MD2 : S_FINISH;
            end
         end
         S_MD2: state_in = S_MD2W;
         S_MD2W: begin
            if (md_sts.done) begin
               res_in   = md_q;
               ovf_in   = md_sts.ovf;
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            rsp_vld_in = 1'b1;
            if (ovf_ff || res_ff[63]) begin
               rsp_in.converted_amount = Max63;
               rsp_in.status = ST_OVERFLOW;
            end else begin
               rsp_in.converted_amount = res_ff[62:0];
               rsp_in.status = kind_ff;
            end
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         scan_len_ff <= '0;
         bridge_ff   <= '0;
         rsp_vld_ff  <= 1'b0;
         rd_vld_ff   <= 1'b0;
         leg_ff      <= 2'd0;
      end else begin
         state_ff   <= state_in;
         rsp_vld_ff <= rsp_vld_in;
         rd_vld_ff  <= rd_vld_in;
         leg_ff     <= leg_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_RATE_COUNT: scan_len_ff <= csr_data[6:0];
               CSR_BRIDGE:     bridge_ff   <= csr_data[7:0];
               default: ;
            endcase
         end
      end
      if (state_ff == S_IDLE && start) begin
         req_ff <= req_payload;
      end
      idx_ff  <= idx_in;
      inv_ff  <= inv_in;
      r1_ff   <= r1_in;
      r2_ff   <= r2_in;
      kind_ff <= kind_in;
      res_ff  <= res_in;
      ovf_ff  <= ovf_in;
      rsp_ff  <= rsp_in;
   end

   assign busy        = (state_ff != S_IDLE);
   assign csr_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_vld_ff;
   assign rsp_payload = rsp_ff;

   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while busy");
   a_finish_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FINISH |=> rsp_valid) else $error("missing result");
   a_ovf_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status == ST_OVERFLOW) |->
      rsp_payload.converted_amount == Max63) else $error("bad overflow value");

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps

module tb_top
   import rtc_pkg::*;
;

   class conversion_scoreboard;
      logic [7:0]  tbl_base [64];
      logic [7:0]  tbl_quote [64];
      logic [63:0] tbl_rate [64];
      logic [6:0]  scan_len;
      logic [7:0]  bridge;
      rsp_type     expected_conv [$];
      int          errors;

      function new();
         scan_len = '0;
         bridge = '0;
         errors = 0;
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         errors++;
         $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
      endtask

      function void set_reg(logic idx, logic [63:0] data);
         if (idx == CSR_RATE_COUNT)
            scan_len = data[6:0];
         else
            bridge = data[7:0];
      endfunction

      // exact (x*y)/d; quotient wider than 64 bits flags overflow
      function logic [63:0] scale_div(logic [63:0] x, logic [63:0] y, logic [63:0] d,
                                      inout logic ovf);
         logic [127:0] prod;
         prod = {64'd0, x} * {64'd0, y};
         if (d == 0)
            return '0;
         if (prod[127:64] >= d) begin
            ovf = 1'b1;
            return '1;
         end
         return 64'(prod / {64'd0, d});
      endfunction

      function bit lookup_leg(logic [7:0] from_c, logic [7:0] to_c,
                              output logic [63:0] rate, output logic [2:0] kind);
         int n;
         logic dummy;
         n = (scan_len > 64) ? 64 : scan_len;
         dummy = 1'b0;
         rate = '0;
         kind = ST_DIRECT;
         for (int i = 0; i < n; i++)
            if (tbl_base[i] == from_c && tbl_quote[i] == to_c) begin
               rate = tbl_rate[i];
               return 1'b1;
            end
         for (int i = 0; i < n; i++)
            if (tbl_base[i] == to_c && tbl_quote[i] == from_c && tbl_rate[i] != 0) begin
               rate = scale_div(Scale1e8, Scale1e8, tbl_rate[i], dummy);
               kind = ST_INVERSE;
               return 1'b1;
            end
         return 1'b0;
      endfunction

      function void note(req_type_type r);
         logic [63:0] res, rate, r1, r2, midv;
         logic [2:0]  st, kind, k1, k2;
         logic        ovf;
         rsp_type     e;
         res = '0;
         ovf = 1'b0;
         if (r.req_type == REQ_WRITE) begin
            tbl_base[r.entry_slot] = r.entry_base;
            tbl_quote[r.entry_slot] = r.entry_quote;
            tbl_rate[r.entry_slot] = r.entry_rate;
            st = ST_WRITTEN;
         end else if (r.amount[63]) begin
            st = ST_BAD;
         end else if (r.from_currency == r.to_currency) begin
            res = r.amount;
            st = ST_DIRECT;
         end else if (lookup_leg(r.from_currency, r.to_currency, rate, kind)) begin
            res = scale_div(r.amount, rate, Scale1e8, ovf);
            st = kind;
         end else if (r.from_currency != bridge && r.to_currency != bridge &&
                      lookup_leg(r.from_currency, bridge, r1, k1) &&
                      lookup_leg(bridge, r.to_currency, r2, k2)) begin
            midv = scale_div(r.amount, r1, Scale1e8, ovf);
            if (!ovf)
               res = scale_div(midv, r2, Scale1e8, ovf);
            st = ST_BRIDGE;
         end else begin
            st = ST_NOTFOUND;
         end
         if (ovf || res > {1'b0, Max63}) begin
            res = {1'b0, Max63};
            st = ST_OVERFLOW;
         end
         e.converted_amount = res[62:0];
         e.status = st;
         expected_conv.push_back(e);
      endfunction

      task check(rsp_type got);
         rsp_type want;
         if (expected_conv.size() == 0) begin
            report("unexpected result", {61'd0, got.status}, '0);
            return;
         end
         want = expected_conv.pop_front();
         if (got.status != want.status)
            report("status", {61'd0, got.status}, {61'd0, want.status});
         if (got.converted_amount != want.converted_amount)
            report("converted_amount", {1'b0, got.converted_amount},
                   {1'b0, want.converted_amount});
      endtask
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_type_type req_payload = '0;
   logic         rsp_valid;
   rsp_type      rsp_payload;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic         csr_index = CSR_RATE_COUNT;
   logic [63:0]  csr_data = '0;

   conversion_scoreboard sb = new();
   int idle_pct = 0;

   rate_table_convert_unit i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_valid(rsp_valid), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check(rsp_payload);
   end

   // start is left high when the next transfer follows back to back
   task send(req_type_type r);
      int gap;
      start <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (busy);
      sb.note(r);
      gap = 0;
      while ($urandom_range(99) < idle_pct && gap < 200)
         gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task drain();
      start <= 1'b0;
      while (sb.expected_conv.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task write_reg(logic idx, logic [63:0] data);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, data);
      csr_valid <= 1'b0;
   endtask

   task put_rate(int slot, int b, int q, logic [63:0] rate);
      req_type_type r;
      r = '0;
      r.req_type = REQ_WRITE;
      r.entry_slot = 6'(slot);
      r.entry_base = 8'(b);
      r.entry_quote = 8'(q);
      r.entry_rate = rate;
      r.amount = {$urandom, $urandom};
      send(r);
   endtask

   task query(int from_c, int to_c, logic [63:0] amt);
      req_type_type r;
      r = '0;
      r.req_type = REQ_QUERY;
      r.amount = amt;
      r.from_currency = 8'(from_c);
      r.to_currency = 8'(to_c);
      send(r);
   endtask

   function logic [63:0] pick_rate();
      case ($urandom_range(9))
         0: return '0;
         1: return 64'($urandom_range(1, 3));
         2: return {$urandom, $urandom};
         default: return 64'($urandom_range(1000000, 1000000000));
      endcase
   endfunction

   function logic [63:0] pick_amount();
      case ($urandom_range(9))
         0: return {1'b1, 31'($urandom), $urandom};
         1: return {1'b0, 31'($urandom), $urandom};
         2: return '0;
         default: return 64'($urandom_range(0, 2000000000));
      endcase
   endfunction

   function int pick_cur();
      return ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(11);
   endfunction

   initial begin
      req_type_type r;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty search and the cases that need no table
      write_reg(CSR_RATE_COUNT, 64'd0);
      write_reg(CSR_BRIDGE, 64'd0);
      query(1, 2, 64'd5);
      query(1, 2, 64'h8000_0000_0000_0000);
      query(3, 3, 64'h7FFF_FFFF_FFFF_FFFF);
      query(255, 0, '1);

      // fill every slot so no search ever touches an unwritten entry
      put_rate(0, 1, 2, 64'd200000000);
      put_rate(1, 3, 4, 64'd0);
      put_rate(2, 5, 6, 64'd1);
      put_rate(3, 1, 9, 64'd50000000);
      put_rate(4, 9, 7, 64'd300000000);
      put_rate(5, 255, 0, '1);
      for (int i = 6; i < 64; i++)
         put_rate(i, pick_cur(), pick_cur(), pick_rate());

      write_reg(CSR_RATE_COUNT, 64'd6);
      write_reg(CSR_BRIDGE, 64'd9);
      query(1, 2, 64'd12345);
      query(2, 1, 64'd12345);
      query(3, 4, 64'd777);
      query(4, 3, 64'd777);
      query(6, 5, 64'd1000);
      query(1, 7, 64'd1000000);
      query(7, 1, 64'd1000000);
      query(1, 2, 64'h7FFF_FFFF_FFFF_FFFF);
      query(1, 2, 64'd0);
      query(9, 2, 64'd10);
      query(0, 255, 64'h7FFF_FFFF_FFFF_FFFF);
      write_reg(CSR_RATE_COUNT, 64'd127);
      write_reg(CSR_BRIDGE, 64'd255);
      query(1, 2, 64'd99);
      query(6, 1, 64'd99);
      write_reg(CSR_RATE_COUNT, 64'd64);
      query(2, 1, 64'd99);

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: idle_pct = 0;
            1: idle_pct = 85;
            2: idle_pct = 35;
            default: idle_pct = 0;
         endcase
         write_reg(CSR_RATE_COUNT, (ph == 3) ? 64'd127 : 64'($urandom_range(1, 64)));
         write_reg(CSR_BRIDGE, 64'(($urandom_range(3) == 0) ? $urandom_range(255)
                                                              : $urandom_range(11)));
         for (int n = 0; n < 205; n++) begin
            if (ph == 1 && n == 100)
               drain();
            r = '0;
            r.req_type = ($urandom_range(4) == 0) ? REQ_WRITE : REQ_QUERY;
            r.amount = pick_amount();
            r.from_currency = 8'(pick_cur());
            r.to_currency = 8'(pick_cur());
            r.entry_slot = 6'($urandom_range(63));
            r.entry_base = 8'(pick_cur());
            r.entry_quote = 8'(pick_cur());
            r.entry_rate = pick_rate();
            send(r);
         end
      end

      start <= 1'b0;
      while (sb.expected_conv.size() != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #40000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

[rate_table_convert_unit.f]
hw/rtl/rtc_pkg.sv
hw/rtl/rtc_muldiv.sv
hw/rtl/rate_table_convert_unit.sv
bench/tb_top.sv
